// ----- hw/rtl/gf256_arithmetic_unit_macros.svh -----
// assertion macros for the gf256 arithmetic unit
`ifndef GF256_ARITHMETIC_UNIT_MACROS_SVH
`define GF256_ARITHMETIC_UNIT_MACROS_SVH

// same-cycle implication, checked on every rising clock edge outside reset
`define GFAU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GFAU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/gfau_pkg.sv -----
// types, action codes and field helpers for the gf256 arithmetic unit
package gfau_pkg;

  localparam logic [2:0] ACT_ADD  = 3'd0;
  localparam logic [2:0] ACT_MUL  = 3'd1;
  localparam logic [2:0] ACT_PDIV = 3'd2;
  localparam logic [2:0] ACT_INV  = 3'd3;
  localparam logic [2:0] ACT_FDIV = 3'd4;

  // low byte of x^8+x^4+x^3+x+1
  localparam logic [7:0] GF_REDUCE = 8'h1B;
  // a^254 is the inverse of a nonzero a
  localparam logic [7:0] INV_EXP   = 8'hFE;
  // last bit position of a byte
  localparam logic [2:0] BIT_LAST  = 3'd7;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] operand_a;
    logic [7:0] operand_b;
  } gfau_in_t;

  typedef struct packed {
    logic [7:0] result;
    logic [7:0] remainder;
    logic       divide_error;
  } gfau_out_t;

  // multiply by x modulo the field polynomial
  function automatic logic [7:0] xtime(input logic [7:0] v);
    logic [7:0] s;
    s = {v[6:0], 1'b0};
    if (v[7]) begin
      s = s ^ GF_REDUCE;
    end
    return s;
  endfunction

  // degree of a nonzero polynomial
  function automatic logic [2:0] poly_deg(input logic [7:0] v);
    logic [2:0] d;
    d = '0;
    for (int i = 0; i < 8; i++) begin
      if (v[i]) begin
        d = 3'(i);
      end
    end
    return d;
  endfunction

endpackage

// ----- hw/rtl/gf256_arithmetic_unit.sv -----
// gf256 arithmetic unit: add, bit-serial multiply, inverse, field divide and polynomial division
//
// usage
//   one input word (action, operand_a, operand_b) is taken at a rising edge
//   with start high and busy low. exactly one result word (result,
//   remainder, divide_error) follows on res_o, marked by valid_o for one
//   cycle. the receiver cannot hold it off, so it must take it then.
// operation per action, up to the valid_o cycle
//   add, unused action codes, zero divisor or zero inverse operand: registered directly
//   multiply: one multiplier bit per cycle through a shift-and-add unit
//   polynomial divide: one quotient bit per cycle
//   inverse: a^254 by square-and-multiply in eight steps; in each step the square
//     and the conditional product run in two serial multipliers
//   field divide: inverse of b, then one more serial multiply by a
// throughput
//   one word at a time; busy drops in the cycle that valid_o is high, so the
//   next word can be taken at the edge that ends that cycle
// reset
//   rst_ni low clears the sequencer and the strobe; no result is pending
module gf256_arithmetic_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  gfau_pkg::gfau_in_t data_i,
  output logic               valid_o,
  output gfau_pkg::gfau_out_t res_o
);

`include "gf256_arithmetic_unit_macros.svh"

  // sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_INV  = 2'd2;
  localparam logic [1:0] ST_DIV  = 2'd3;

  // control
  logic [1:0] state_q, state_d;
  logic       valid_q, valid_d;
  logic [2:0] cnt_q, cnt_d;     // bit counter, or quotient position in divide
  logic [2:0] step_q, step_d;   // exponent bit of the inverse
  logic       fdiv_q, fdiv_d;   // inverse is followed by a multiply

  // serial multiplier 1: conditional product in the inverse, plain multiply
  logic [7:0] m1_acc_q, m1_acc_d, m1_x_q, m1_x_d, m1_y_q, m1_y_d;
  // serial multiplier 2: squaring in the inverse
  logic [7:0] m2_acc_q, m2_acc_d, m2_x_q, m2_x_d, m2_y_q, m2_y_d;
  // inverse accumulator
  logic [7:0] inv_r_q, inv_r_d;
  // dividend kept for the field divide
  logic [7:0] a_q, a_d;
  // polynomial division: partial remainder, quotient, aligned divisor
  logic [7:0] div_r_q, div_r_d, div_q_q, div_q_d, div_d_q, div_d_d;
  logic [2:0] db_q, db_d;       // degree of the divisor
  // result word
  gfau_pkg::gfau_out_t res_q, res_d;

  // one step of each serial unit
  logic [7:0] m1_acc_s, m2_acc_s;
  logic [7:0] div_r_s, div_q_s;
  logic [2:0] div_idx;
  logic       div_hit;
  logic [7:0] r_new, p_new;
  logic [7:0] inv_op;
  logic [2:0] b_deg;
  logic [3:0] div_span;

  // shift-and-add: fold in x when the low multiplier bit is set
  assign m1_acc_s = m1_acc_q ^ (m1_y_q[0] ? m1_x_q : 8'h00);
  assign m2_acc_s = m2_acc_q ^ (m2_y_q[0] ? m2_x_q : 8'h00);

  // long division: test the remainder bit under the divisor's top bit
  assign div_idx  = db_q + cnt_q;
  assign div_hit  = div_r_q[div_idx];
  assign div_r_s  = div_hit ? (div_r_q ^ div_d_q) : div_r_q;
  assign div_q_s  = div_hit ? (div_q_q | (8'd1 << cnt_q)) : div_q_q;
  assign div_span = {1'b0, db_q} + {1'b0, cnt_q};

  // end of an inverse step: take the product only where the exponent bit is set
  assign r_new  = gfau_pkg::INV_EXP[step_q] ? m1_acc_s : inv_r_q;
  assign p_new  = m2_acc_s;

  assign inv_op = (data_i.action == gfau_pkg::ACT_INV) ? data_i.operand_a
                                                      : data_i.operand_b;
  assign b_deg  = gfau_pkg::poly_deg(data_i.operand_b);

  assign busy    = (state_q != ST_IDLE);
  assign valid_o = valid_q;
  assign res_o   = res_q;

  always_comb begin
    state_d  = state_q;
    valid_d  = 1'b0;
    cnt_d    = cnt_q;
    step_d   = step_q;
    fdiv_d   = fdiv_q;
    m1_acc_d = m1_acc_q;
    m1_x_d   = m1_x_q;
    m1_y_d   = m1_y_q;
    m2_acc_d = m2_acc_q;
    m2_x_d   = m2_x_q;
    m2_y_d   = m2_y_q;
    inv_r_d  = inv_r_q;
    a_d      = a_q;
    div_r_d  = div_r_q;
    div_q_d  = div_q_q;
    div_d_d  = div_d_q;
    db_d     = db_q;
    res_d    = res_q;

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          unique case (data_i.action) inside
            gfau_pkg::ACT_ADD: begin
              res_d   = '{result: data_i.operand_a ^ data_i.operand_b,
                          remainder: 8'h00, divide_error: 1'b0};
              valid_d = 1'b1;
            end
            gfau_pkg::ACT_MUL: begin
              m1_acc_d = 8'h00;
              m1_x_d   = data_i.operand_a;
              m1_y_d   = data_i.operand_b;
              cnt_d    = '0;
              state_d  = ST_MUL;
            end
            gfau_pkg::ACT_PDIV: begin
              if (data_i.operand_b == 8'h00) begin
                res_d   = '{result: 8'h00, remainder: 8'h00, divide_error: 1'b1};
                valid_d = 1'b1;
              end else begin
                // align the divisor's top bit with bit 7
                div_r_d = data_i.operand_a;
                div_q_d = 8'h00;
                db_d    = b_deg;
                div_d_d = data_i.operand_b << (gfau_pkg::BIT_LAST - b_deg);
                cnt_d   = gfau_pkg::BIT_LAST - b_deg;
                state_d = ST_DIV;
              end
            end
            gfau_pkg::ACT_INV, gfau_pkg::ACT_FDIV: begin
              if (inv_op == 8'h00) begin
                res_d   = '{result: 8'h00, remainder: 8'h00, divide_error: 1'b1};
                valid_d = 1'b1;
              end else begin
                inv_r_d  = 8'h01;
                m1_acc_d = 8'h00;
                m1_x_d   = 8'h01;
                m1_y_d   = inv_op;
                m2_acc_d = 8'h00;
                m2_x_d   = inv_op;
                m2_y_d   = inv_op;
                a_d      = data_i.operand_a;
                fdiv_d   = (data_i.action == gfau_pkg::ACT_FDIV);
                cnt_d    = '0;
                step_d   = '0;
                state_d  = ST_INV;
              end
            end
            default: begin
              // unused action codes give an all-zero word
              res_d   = '{result: 8'h00, remainder: 8'h00, divide_error: 1'b0};
              valid_d = 1'b1;
            end
          endcase
        end
      end

      ST_MUL: begin
        m1_acc_d = m1_acc_s;
        m1_x_d   = gfau_pkg::xtime(m1_x_q);
        m1_y_d   = m1_y_q >> 1;
        cnt_d    = cnt_q + 3'd1;
        if (cnt_q == gfau_pkg::BIT_LAST) begin
          res_d   = '{result: m1_acc_s, remainder: 8'h00, divide_error: 1'b0};
          valid_d = 1'b1;
          state_d = ST_IDLE;
        end
      end

      ST_INV: begin
        m1_acc_d = m1_acc_s;
        m1_x_d   = gfau_pkg::xtime(m1_x_q);
        m1_y_d   = m1_y_q >> 1;
        m2_acc_d = m2_acc_s;
        m2_x_d   = gfau_pkg::xtime(m2_x_q);
        m2_y_d   = m2_y_q >> 1;
        cnt_d    = cnt_q + 3'd1;
        if (cnt_q == gfau_pkg::BIT_LAST) begin
          inv_r_d = r_new;
          if (step_q == gfau_pkg::BIT_LAST) begin
            if (fdiv_q) begin
              // a times the inverse of b
              m1_acc_d = 8'h00;
              m1_x_d   = a_q;
              m1_y_d   = r_new;
              state_d  = ST_MUL;
            end else begin
              res_d   = '{result: r_new, remainder: 8'h00, divide_error: 1'b0};
              valid_d = 1'b1;
              state_d = ST_IDLE;
            end
          end else begin
            step_d   = step_q + 3'd1;
            m1_acc_d = 8'h00;
            m1_x_d   = r_new;
            m1_y_d   = p_new;
            m2_acc_d = 8'h00;
            m2_x_d   = p_new;
            m2_y_d   = p_new;
          end
        end
      end

      ST_DIV: begin
        div_r_d = div_r_s;
        div_q_d = div_q_s;
        div_d_d = div_d_q >> 1;
        cnt_d   = cnt_q - 3'd1;
        if (cnt_q == 3'd0) begin
          res_d   = '{result: div_q_s, remainder: div_r_s, divide_error: 1'b0};
          valid_d = 1'b1;
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= 1'b0;
      cnt_q   <= '0;
      step_q  <= '0;
      fdiv_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      cnt_q   <= cnt_d;
      step_q  <= step_d;
      fdiv_q  <= fdiv_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    m1_acc_q <= m1_acc_d;
    m1_x_q   <= m1_x_d;
    m1_y_q   <= m1_y_d;
    m2_acc_q <= m2_acc_d;
    m2_x_q   <= m2_x_d;
    m2_y_q   <= m2_y_d;
    inv_r_q  <= inv_r_d;
    a_q      <= a_d;
    div_r_q  <= div_r_d;
    div_q_q  <= div_q_d;
    div_d_q  <= div_d_d;
    db_q     <= db_d;
    res_q    <= res_d;
  end

  // an error word carries nothing else
  `GFAU_ASSERT_NOW(a_err_zero, valid_o && res_o.divide_error,
                   (res_o.result == 8'h00) && (res_o.remainder == 8'h00),
                   "error word with nonzero data")

  // the tested remainder bit never runs past bit 7
  `GFAU_ASSERT_NOW(a_div_span, state_q == ST_DIV, div_span <= 4'd7,
                   "division bit position out of range")

  // a word is only shown once the sequencer is free again
  `GFAU_ASSERT_NOW(a_valid_idle, valid_o, !busy,
                   "result strobe while busy")

  // add gives its word in the next cycle without occupying the unit
  `GFAU_ASSERT_NEXT(a_add_fast,
                    start && !busy && (data_i.action == gfau_pkg::ACT_ADD),
                    valid_o && !busy, "add did not finish in one cycle")

endmodule
